FILE: src/decision_stump_search_macros.svh
// Assertion macros shared by the decision stump search RTL.
`ifndef DECISION_STUMP_SEARCH_MACROS_SVH
`define DECISION_STUMP_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DSS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DSS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSS_ASSERT_SAME(name, ante, cons, msg)
`define DSS_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: src/dss_pkg.sv
package dss_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int COORD_BITS  = 10;
    localparam int WEIGHT_BITS = 16;

    localparam int PTR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CFG_W = 11;
    localparam int ERR_W = 26;
    localparam int SUM_W = WEIGHT_BITS + CNT_W;
    localparam int ACC_W = (SUM_W > ERR_W) ? SUM_W : ERR_W;
    localparam int COORD_SPAN = 1 << COORD_BITS;

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    typedef struct packed {
        logic [COORD_BITS-1:0]  row;
        logic [COORD_BITS-1:0]  col;
        logic                   pos;
        logic [WEIGHT_BITS-1:0] wt;
    } t_point;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef enum logic [0:0] {
        REG_ROWS_IN_USE,
        REG_COLS_IN_USE
    } t_reg_idx;

    typedef struct packed {
        logic                  start;
        logic                  rd_vld;
        logic                  cmp;
        logic                  feat;
        logic [COORD_BITS-1:0] thr;
    } t_acc_ctl;

    // last threshold for a threshold count register, clamped to 1..COORD_SPAN
    function automatic logic [COORD_BITS-1:0] thr_max(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        begin
            if (v == '0) begin
                c = CFG_W'(1);
            end else if (v > CFG_W'(COORD_SPAN)) begin
                c = CFG_W'(COORD_SPAN);
            end else begin
                c = v;
            end
            thr_max = COORD_BITS'(c - CFG_W'(1));
        end
    endfunction

endpackage

FILE: src/dss_pt_if.sv
interface dss_pt_if;
    logic                             valid;
    logic                             ready;
    logic [dss_pkg::COORD_BITS-1:0]  row_coord;
    logic [dss_pkg::COORD_BITS-1:0]  col_coord;
    logic                             class_positive;
    logic [dss_pkg::WEIGHT_BITS-1:0] weight;
    logic                             last_point;

    modport source (
        output valid, row_coord, col_coord, class_positive, weight, last_point,
        input  ready
    );
    modport sink (
        input  valid, row_coord, col_coord, class_positive, weight, last_point,
        output ready
    );
endinterface

FILE: src/dss_res_if.sv
interface dss_res_if;
    logic                            valid;
    logic                            ready;
    logic                            best_feature;
    logic [dss_pkg::COORD_BITS-1:0] best_threshold;
    logic                            below_is_positive;
    logic [dss_pkg::ERR_W-1:0]      best_error;
    logic                            overflowed;

    modport source (
        output valid, best_feature, best_threshold, below_is_positive, best_error, overflowed,
        input  ready
    );
    modport sink (
        input  valid, best_feature, best_threshold, below_is_positive, best_error, overflowed,
        output ready
    );
endinterface

FILE: src/dss_acc.sv
`include "decision_stump_search_macros.svh"

module dss_acc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dss_pkg::t_acc_ctl              i_ctl,
    input  dss_pkg::t_point                i_point,
    output logic                           o_best_feat,
    output logic [dss_pkg::COORD_BITS-1:0] o_best_thr,
    output logic                           o_best_pos,
    output logic [dss_pkg::ACC_W-1:0]      o_best_err
);

    logic [dss_pkg::ACC_W-1:0]      r_acc0;
    logic [dss_pkg::ACC_W-1:0]      r_acc1;
    logic                           r_have;
    logic                           r_best_feat;
    logic [dss_pkg::COORD_BITS-1:0] r_best_thr;
    logic                           r_best_pos;
    logic [dss_pkg::ACC_W-1:0]      r_best_err;

    logic [dss_pkg::COORD_BITS-1:0] x;
    logic                           below;
    logic                           miss0;
    logic [dss_pkg::ACC_W-1:0]      wt_ext;
    logic                           take0;
    logic                           take1;
    logic [dss_pkg::ACC_W-1:0]      mid_err;

    // polarity 0: below predicts -1; it misses when below equals the label
    assign x      = i_ctl.feat ? i_point.col : i_point.row;
    assign below  = x < i_ctl.thr;
    assign miss0  = below == i_point.pos;
    assign wt_ext = dss_pkg::ACC_W'(i_point.wt);

    assign take0   = !r_have || (r_acc0 < r_best_err);
    assign mid_err = take0 ? r_acc0 : r_best_err;
    assign take1   = r_acc1 < mid_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc0 <= '0;
            r_acc1 <= '0;
            r_have <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_have <= 1'b0;
            end else if (i_ctl.cmp) begin
                r_have <= 1'b1;
            end
            if (i_ctl.start || i_ctl.cmp) begin
                r_acc0 <= '0;
                r_acc1 <= '0;
            end else if (i_ctl.rd_vld) begin
                if (miss0) begin
                    r_acc0 <= r_acc0 + wt_ext;
                end else begin
                    r_acc1 <= r_acc1 + wt_ext;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            if (take1) begin
                r_best_feat <= i_ctl.feat;
                r_best_thr  <= i_ctl.thr;
                r_best_pos  <= 1'b1;
                r_best_err  <= r_acc1;
            end else if (take0) begin
                r_best_feat <= i_ctl.feat;
                r_best_thr  <= i_ctl.thr;
                r_best_pos  <= 1'b0;
                r_best_err  <= r_acc0;
            end
        end
    end

    assign o_best_feat = r_best_feat;
    assign o_best_thr  = r_best_thr;
    assign o_best_pos  = r_best_pos;
    assign o_best_err  = r_best_err;

    `DSS_ASSERT_NEXT(a_acc_clear, i_ctl.cmp, r_acc0 == '0 && r_acc1 == '0, "sums not cleared")
    `DSS_ASSERT_NEXT(a_have_set, i_ctl.cmp && !i_ctl.start, r_have, "best not marked valid")
    `DSS_ASSERT_NEXT(a_start_clear, i_ctl.start, !r_have && r_acc0 == '0, "start not cleared")

endmodule

FILE: src/decision_stump_search.sv
// Channel   | Dir | Modport | Content
// i_pts     | in  | sink    | one labelled, weighted point per item
// o_res     | out | source  | best stump of the set, one item per set
// i_cfg_*   | in  | -       | threshold counts (index 0 rows, 1 cols)
// Points load one per cycle into a single-port point memory.
// After the last point the search reads the memory once per threshold
// through the one read port.
// No point is taken during the search or while the result waits.
// Reset is synchronous, active low; the point memory is not cleared.
`include "decision_stump_search_macros.svh"

module decision_stump_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [dss_pkg::CFG_W-1:0]     i_cfg_data,
    dss_pt_if.sink                        i_pts,
    dss_res_if.source                     o_res
);

    dss_pkg::t_point mem [dss_pkg::MAX_POINTS];

    dss_pkg::t_state                r_state;
    dss_pkg::t_state                n_state;
    logic [dss_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_drop;
    logic [dss_pkg::CFG_W-1:0]      r_rows;
    logic [dss_pkg::CFG_W-1:0]      r_cols;
    logic                           r_feat;
    logic [dss_pkg::COORD_BITS-1:0] r_thr;
    logic [dss_pkg::CNT_W-1:0]      r_addr;
    logic                           r_rd_vld;
    logic                           r_rd_last;
    logic                           r_cmp;
    dss_pkg::t_point                r_rd_data;

    dss_pkg::t_point   wr_point;
    dss_pkg::t_acc_ctl acc_ctl;
    logic              in_acc;
    logic              out_acc;
    logic              full;
    logic              thr_last;
    logic              final_thr;
    logic              issue_last;
    logic              rd_en;
    logic              in_ready;
    logic              out_valid;

    logic                           best_feat;
    logic [dss_pkg::COORD_BITS-1:0] best_thr;
    logic                           best_pos;
    logic [dss_pkg::ACC_W-1:0]      best_err;

    assign in_acc     = i_pts.valid && i_pts.ready;
    assign out_acc    = o_res.valid && o_res.ready;
    assign full       = r_cnt == dss_pkg::CNT_W'(dss_pkg::MAX_POINTS);
    assign thr_last   = r_thr == dss_pkg::thr_max(r_feat ? r_cols : r_rows);
    assign final_thr  = r_feat && thr_last;
    assign issue_last = r_addr == (r_cnt - dss_pkg::CNT_W'(1));

    assign wr_point.row = i_pts.row_coord;
    assign wr_point.col = i_pts.col_coord;
    assign wr_point.pos = i_pts.class_positive;
    assign wr_point.wt  = i_pts.weight;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dss_pkg::ST_LOAD: begin
                if (in_acc && i_pts.last_point) begin
                    n_state = dss_pkg::ST_SCAN;
                end
            end
            dss_pkg::ST_SCAN: begin
                if (issue_last) begin
                    n_state = dss_pkg::ST_DRAIN;
                end
            end
            dss_pkg::ST_DRAIN: begin
                if (r_cmp) begin
                    n_state = final_thr ? dss_pkg::ST_OUT : dss_pkg::ST_SCAN;
                end
            end
            dss_pkg::ST_OUT: begin
                if (out_acc) begin
                    n_state = dss_pkg::ST_LOAD;
                end
            end
            default: n_state = dss_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        out_valid = 1'b0;
        unique case (r_state)
            dss_pkg::ST_LOAD:  in_ready  = 1'b1;
            dss_pkg::ST_SCAN:  rd_en     = 1'b1;
            dss_pkg::ST_DRAIN: rd_en     = 1'b0;
            dss_pkg::ST_OUT:   out_valid = 1'b1;
            default:           in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dss_pkg::ST_LOAD;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_rows    <= dss_pkg::CFG_W'(dss_pkg::COORD_SPAN);
            r_cols    <= dss_pkg::CFG_W'(dss_pkg::COORD_SPAN);
            r_feat    <= 1'b0;
            r_thr     <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_cmp     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= rd_en;
            r_rd_last <= rd_en && issue_last;
            r_cmp     <= r_rd_vld && r_rd_last;

            if (i_cfg_we) begin
                unique case (dss_pkg::t_reg_idx'(i_cfg_idx))
                    dss_pkg::REG_ROWS_IN_USE: r_rows <= i_cfg_data;
                    dss_pkg::REG_COLS_IN_USE: r_cols <= i_cfg_data;
                endcase
            end

            if (in_acc) begin
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + dss_pkg::CNT_W'(1);
                end
                if (i_pts.last_point) begin
                    r_feat <= 1'b0;
                    r_thr  <= '0;
                    r_addr <= '0;
                end
            end

            if (rd_en) begin
                r_addr <= r_addr + dss_pkg::CNT_W'(1);
            end

            if (r_cmp && (r_state == dss_pkg::ST_DRAIN) && !final_thr) begin
                r_addr <= '0;
                if (thr_last) begin
                    r_feat <= 1'b1;
                    r_thr  <= '0;
                end else begin
                    r_thr <= r_thr + dss_pkg::COORD_BITS'(1);
                end
            end

            if (out_acc) begin
                r_cnt  <= '0;
                r_drop <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !full) begin
            mem[r_cnt[dss_pkg::PTR_W-1:0]] <= wr_point;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_addr[dss_pkg::PTR_W-1:0]];
        end
    end

    assign acc_ctl.start  = in_acc && i_pts.last_point;
    assign acc_ctl.rd_vld = r_rd_vld;
    assign acc_ctl.cmp    = r_cmp;
    assign acc_ctl.feat   = r_feat;
    assign acc_ctl.thr    = r_thr;

    dss_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (acc_ctl),
        .i_point     (r_rd_data),
        .o_best_feat (best_feat),
        .o_best_thr  (best_thr),
        .o_best_pos  (best_pos),
        .o_best_err  (best_err)
    );

    assign i_pts.ready             = in_ready;
    assign o_res.valid             = out_valid;
    assign o_res.best_feature      = best_feat;
    assign o_res.best_threshold    = best_thr;
    assign o_res.below_is_positive = best_pos;
    assign o_res.best_error        = (best_err > dss_pkg::ACC_W'(dss_pkg::ERR_MAX)) ?
                                     dss_pkg::ERR_MAX : dss_pkg::ERR_W'(best_err);
    assign o_res.overflowed        = r_drop;

    `DSS_ASSERT_SAME(a_no_read_in_load, r_state == dss_pkg::ST_LOAD, !r_rd_vld, "read during load")
    `DSS_ASSERT_SAME(a_cmp_in_drain, r_cmp, r_state == dss_pkg::ST_DRAIN, "compare outside drain")
    `DSS_ASSERT_NEXT(a_drop_on_full, in_acc && full, r_drop, "dropped point not flagged")
    `DSS_ASSERT_SAME(a_result_has_points, o_res.valid, r_cnt != '0, "result from empty set")

endmodule

FILE: tb/decision_stump_search_tb.sv
`timescale 1ns / 1ps

module decision_stump_search_tb;

    // Worst case is a phase of one-point sets at 1040 thresholds.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int LONG_HOLD   = 600;
    localparam int MAX_IDLE    = 14;

    typedef struct {
        logic [dss_pkg::COORD_BITS-1:0]  row;
        logic [dss_pkg::COORD_BITS-1:0]  col;
        logic                            pos;
        logic [dss_pkg::WEIGHT_BITS-1:0] wt;
        logic                            is_last;
        logic                            drain_first;
    } t_pt_item;

    typedef struct packed {
        logic                           feat;
        logic [dss_pkg::COORD_BITS-1:0] thr;
        logic                           below_pos;
        logic [dss_pkg::ERR_W-1:0]      err;
        logic                           ovf;
    } t_stump;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [0:0]                cfg_idx;
    logic [dss_pkg::CFG_W-1:0] cfg_data;

    dss_pt_if  pts();
    dss_res_if res();

    decision_stump_search dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_pts     (pts),
        .o_res     (res)
    );

    // predictor state
    dss_pkg::t_point           pt_mem [dss_pkg::MAX_POINTS];
    int                        stored;
    logic                      dropped;
    logic [dss_pkg::CFG_W-1:0] rows_cfg;
    logic [dss_pkg::CFG_W-1:0] cols_cfg;

    t_pt_item point_q[$];
    t_stump   stump_q[$];

    t_pt_item cur_pt;
    logic     drv_busy;
    int       send_gap;
    int       rx_wait;
    logic     quiet;
    logic     hold_req;
    logic     hold_taken;
    int       hold_left;

    int n_errors;
    int points_sent;
    int points_queued;
    int stumps_seen;
    int reg_writes;
    int cycle_cnt;

    function automatic int thr_count(input logic [dss_pkg::CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > dss_pkg::COORD_SPAN) return dss_pkg::COORD_SPAN;
        return int'(v);
    endfunction

    function automatic t_stump search_best_stump();
        t_stump                         best;
        logic [63:0]                    err;
        logic [63:0]                    best_err;
        logic [dss_pkg::COORD_BITS-1:0] x;
        logic                           pred;
        int                             span;
        best     = '0;
        best_err = '1;
        for (int f = 0; f < 2; f++) begin
            span = thr_count(f ? cols_cfg : rows_cfg);
            for (int t = 0; t < span; t++) begin
                for (int p = 0; p < 2; p++) begin
                    err = '0;
                    for (int i = 0; i < stored; i++) begin
                        x    = f ? pt_mem[i].col : pt_mem[i].row;
                        pred = (x < t) ? (p == 1) : (p == 0);
                        if (pred != pt_mem[i].pos) err += 64'(pt_mem[i].wt);
                    end
                    // strict compare keeps the earliest stump on ties
                    if (err < best_err) begin
                        best_err       = err;
                        best.feat      = (f == 1);
                        best.thr       = dss_pkg::COORD_BITS'(t);
                        best.below_pos = (p == 1);
                    end
                end
            end
        end
        best.err = (best_err > dss_pkg::ERR_MAX) ? dss_pkg::ERR_MAX
                                                 : best_err[dss_pkg::ERR_W-1:0];
        best.ovf = dropped;
        return best;
    endfunction

    task automatic absorb_point(input t_pt_item it);
        if (stored < dss_pkg::MAX_POINTS) begin
            pt_mem[stored] = '{row: it.row, col: it.col, pos: it.pos, wt: it.wt};
            stored++;
        end else begin
            dropped = 1'b1;
        end
        if (it.is_last) begin
            stump_q.insert(stump_q.size(), search_best_stump());
            stored  = 0;
            dropped = 1'b0;
        end
    endtask

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    task automatic check_stump();
        t_stump want;
        if (stump_q.size() == 0) begin
            $error("result item with no pending expectation");
            n_errors++;
            return;
        end
        want = stump_q.pop_front();
        stumps_seen++;
        cmp_field("best_feature", 32'(want.feat), 32'(res.best_feature));
        cmp_field("best_threshold", 32'(want.thr), 32'(res.best_threshold));
        cmp_field("below_is_positive", 32'(want.below_pos), 32'(res.below_is_positive));
        cmp_field("best_error", 32'(want.err), 32'(res.best_error));
        cmp_field("overflowed", 32'(want.ovf), 32'(res.overflowed));
    endtask

    task automatic queue_point(input logic [dss_pkg::COORD_BITS-1:0] row,
                               input logic [dss_pkg::COORD_BITS-1:0] col, input logic pos,
                               input logic [dss_pkg::WEIGHT_BITS-1:0] wt,
                               input logic is_last, input logic drain_first);
        t_pt_item it;
        it = '{row: row, col: col, pos: pos, wt: wt, is_last: is_last,
               drain_first: drain_first};
        point_q.insert(point_q.size(), it);
        points_queued++;
    endtask

    // Labels mostly follow a hidden stump with some noise, so the search has
    // a meaningful optimum; coordinates mostly sit inside the threshold range.
    task automatic queue_set(input int n, input logic drain);
        logic [dss_pkg::COORD_BITS-1:0]  row;
        logic [dss_pkg::COORD_BITS-1:0]  col;
        logic                            pos;
        logic [dss_pkg::WEIGHT_BITS-1:0] wt;
        int                              rlim;
        int                              clim;
        int                              h;
        int                              f;
        logic                            flip;
        logic                            shaped;
        rlim   = (thr_count(rows_cfg) + 1 > 1023) ? 1023 : thr_count(rows_cfg) + 1;
        clim   = (thr_count(cols_cfg) + 1 > 1023) ? 1023 : thr_count(cols_cfg) + 1;
        shaped = ($urandom_range(0, 2) != 0);
        f      = $urandom_range(0, 1);
        h      = $urandom_range(0, f ? clim : rlim);
        flip   = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
            row = ($urandom_range(0, 3) == 0) ? dss_pkg::COORD_BITS'($urandom)
                                              : dss_pkg::COORD_BITS'($urandom_range(0, rlim));
            col = ($urandom_range(0, 3) == 0) ? dss_pkg::COORD_BITS'($urandom)
                                              : dss_pkg::COORD_BITS'($urandom_range(0, clim));
            if (shaped) begin
                pos = ((f ? col : row) < h) ^ flip;
                if ($urandom_range(0, 5) == 0) pos = !pos;
            end else begin
                pos = 1'($urandom_range(0, 1));
            end
            case ($urandom_range(0, 5))
                0: wt = '0;
                1: wt = '1;
                2: wt = dss_pkg::WEIGHT_BITS'($urandom_range(0, 255));
                default: wt = dss_pkg::WEIGHT_BITS'($urandom);
            endcase
            queue_point(row, col, pos, wt, i == n - 1, drain && (i == 0));
        end
    endtask

    task automatic write_reg(input dss_pkg::t_reg_idx idx,
                             input logic [dss_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == dss_pkg::REG_ROWS_IN_USE) rows_cfg = val;
        else cols_cfg = val;
        reg_writes++;
    endtask

    task automatic wait_idle();
        while (point_q.size() > 0 || drv_busy || stump_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // point driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pts.valid <= 1'b0;
            drv_busy = 1'b0;
            send_gap = 0;
        end else begin
            if (pts.valid && pts.ready) begin
                absorb_point(cur_pt);
                points_sent++;
                drv_busy = 1'b0;
                send_gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (!drv_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (point_q.size() > 0 &&
                             !(point_q[0].drain_first && stump_q.size() > 0)) begin
                    cur_pt   = point_q.pop_front();
                    drv_busy = 1'b1;
                end
            end
            pts.valid          <= drv_busy;
            pts.row_coord      <= cur_pt.row;
            pts.col_coord      <= cur_pt.col;
            pts.class_positive <= cur_pt.pos;
            pts.weight         <= cur_pt.wt;
            pts.last_point     <= cur_pt.is_last;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (res.valid && res.ready) begin
                check_stump();
                rx_wait = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (res.valid && rx_wait > 0) begin
                rx_wait--;
            end
            res.ready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // one long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_left  <= LONG_HOLD;
            hold_taken <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
                     stump_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        int c;
        int goal;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        pts.valid          = 1'b0;
        pts.row_coord      = '0;
        pts.col_coord      = '0;
        pts.class_positive = 1'b0;
        pts.weight         = '0;
        pts.last_point     = 1'b0;
        res.ready          = 1'b0;
        cur_pt             = '{default: '0};
        drv_busy           = 1'b0;
        quiet              = 1'b0;
        hold_req           = 1'b0;
        stored             = 0;
        dropped            = 1'b0;
        rows_cfg           = dss_pkg::CFG_W'(dss_pkg::COORD_SPAN);
        cols_cfg           = dss_pkg::CFG_W'(dss_pkg::COORD_SPAN);
        n_errors           = 0;
        points_sent        = 0;
        points_queued      = 0;
        stumps_seen        = 0;
        reg_writes         = 0;
        cycle_cnt          = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds, corner coordinates, full weights
        queue_point(10'd0, 10'd1023, 1'b1, 16'hFFFF, 1'b0, 1'b0);
        queue_point(10'd1023, 10'd0, 1'b0, 16'hFFFF, 1'b1, 1'b0);
        wait_idle();

        // zero count clamps to one, oversize clamps to full span
        write_reg(dss_pkg::REG_ROWS_IN_USE, 11'd0);
        write_reg(dss_pkg::REG_COLS_IN_USE, 11'd2047);
        queue_point(10'd512, 10'd511, 1'b1, 16'h8000, 1'b1, 1'b0);
        queue_point(10'd3, 10'd4, 1'b0, 16'h0000, 1'b0, 1'b0);
        queue_point(10'd7, 10'd2, 1'b1, 16'h0000, 1'b1, 1'b0);
        queue_point(10'd10, 10'd10, 1'b1, 16'h0100, 1'b0, 1'b0);
        queue_point(10'd10, 10'd10, 1'b0, 16'h0100, 1'b1, 1'b0);
        queue_point(10'd5, 10'd100, 1'b1, 16'h1234, 1'b0, 1'b0);
        queue_point(10'd5, 10'd900, 1'b0, 16'h4321, 1'b0, 1'b0);
        queue_point(10'd5, 10'd300, 1'b1, 16'h00FF, 1'b1, 1'b0);
        wait_idle();

        write_reg(dss_pkg::REG_ROWS_IN_USE, 11'd1025);
        write_reg(dss_pkg::REG_COLS_IN_USE, 11'd1);
        queue_point(10'd600, 10'd0, 1'b0, 16'hFFFF, 1'b0, 1'b0);
        queue_point(10'd200, 10'd1023, 1'b1, 16'hFFFF, 1'b0, 1'b0);
        queue_point(10'd1023, 10'd1023, 1'b0, 16'h0001, 1'b1, 1'b0);
        wait_idle();

        // small counts, zero column count clamps to one
        write_reg(dss_pkg::REG_ROWS_IN_USE, 11'd3);
        write_reg(dss_pkg::REG_COLS_IN_USE, 11'd0);
        queue_set(40, 1'b0);
        queue_set(2, 1'b0);
        wait_idle();

        // long receiver hold while points keep coming, then a drained start
        write_reg(dss_pkg::REG_ROWS_IN_USE, 11'd4);
        write_reg(dss_pkg::REG_COLS_IN_USE, 11'd4);
        quiet    <= 1'b1;
        hold_req <= 1'b1;
        repeat (3) queue_set(3, 1'b0);
        queue_set(3, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: begin r = 1; c = 1; end
                2: begin r = 1024; c = $urandom_range(1, 16); end
                3: begin r = $urandom_range(41, 200); c = $urandom_range(1, 8); end
                default: begin r = $urandom_range(1, 40); c = $urandom_range(1, 40); end
            endcase
            write_reg(dss_pkg::REG_ROWS_IN_USE, dss_pkg::CFG_W'(r));
            write_reg(dss_pkg::REG_COLS_IN_USE, dss_pkg::CFG_W'(c));
            quiet <= (ph == 1 || ph == 4);
            goal = points_queued + 80;
            while (points_queued < goal) begin
                queue_set(($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                      : $urandom_range(1, 10),
                          $urandom_range(0, 7) == 0);
            end
            wait_idle();
        end

        repeat (200) @(posedge i_clk);
        $display("Checked %0d stumps from %0d points over %0d register writes",
                 stumps_seen, points_sent, reg_writes);
        $display("Sets of 1 to 40 points, 1 to 1024 thresholds per feature");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: decision_stump_search.f
+incdir+src
src/dss_pkg.sv
src/dss_pt_if.sv
src/dss_res_if.sv
src/dss_acc.sv
src/decision_stump_search.sv
tb/decision_stump_search_tb.sv
